// ===== design/drp_pkg.sv =====
// Shared types, constants and width functions for the disparity reprojection block.
package drp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int REG_W     = 32;
  localparam int OUT_W     = 48;
  localparam int PROD_W    = 48;
  localparam int W_W       = 49;
  localparam int DV_W      = 48;
  localparam int LANES     = 3;
  localparam int IDX_W     = 3;
  localparam logic signed [REG_W-1:0] FRAC_ONE = 32'sd65536;

  typedef enum logic [IDX_W-1:0] {
    REG_CX_OFFSET    = 3'd0,
    REG_CY_OFFSET    = 3'd1,
    REG_FOCAL_TERM   = 3'd2,
    REG_INV_BASELINE = 3'd3,
    REG_DENOM_OFFSET = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [REG_W-1:0] cx_offset;
    logic signed [REG_W-1:0] cy_offset;
    logic signed [REG_W-1:0] focal_term;
    logic signed [REG_W-1:0] inv_baseline;
    logic signed [REG_W-1:0] denom_offset;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic zero_w;
  } pipe_ctl_t;

  function automatic int num_width(int coord_bits);
    return ((coord_bits + FRAC_BITS > REG_W - 1) ? coord_bits + FRAC_BITS : REG_W - 1) + 2;
  endfunction

  function automatic int divd_width(int coord_bits, int scale);
    return num_width(coord_bits) - 1 + $clog2(scale + 1) + FRAC_BITS;
  endfunction

  function automatic int latency(int coord_bits, int scale);
    return divd_width(coord_bits, scale) + 3;
  endfunction

endpackage

// ===== design/drp_front.sv =====
// Operand stages: disparity product, denominator, numerators and their magnitudes.
module drp_front import drp_pkg::*; #(
  parameter int COORD_BITS   = 12,
  parameter int OUTPUT_SCALE = 16,
  localparam int NUM_W = num_width(COORD_BITS),
  localparam int DQ_W  = divd_width(COORD_BITS, OUTPUT_SCALE)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cfg_t                             cfg,
  input  logic                             accept,
  input  logic [COORD_BITS-1:0]            col,
  input  logic [COORD_BITS-1:0]            row,
  input  logic signed [15:0]               disp,
  output pipe_ctl_t                        ctl,
  output logic [LANES-1:0][DQ_W-1:0]       dq,
  output logic [DV_W-1:0]                  dv,
  output logic [LANES-1:0]                 neg
);

  logic                      v1;
  logic [COORD_BITS-1:0]     x1;
  logic [COORD_BITS-1:0]     y1;
  logic signed [PROD_W-1:0]  p1;
  logic signed [PROD_W-1:0]  prod;

  logic signed [W_W-1:0]     w;
  logic [DV_W-1:0]           wmag;
  logic signed [NUM_W-1:0]   num  [LANES];
  logic [NUM_W-1:0]          mag  [LANES];
  logic [DQ_W-1:0]           scaled [LANES];
  logic [LANES-1:0][DQ_W-1:0] dq_next;
  logic [LANES-1:0]          neg_next;

  assign prod = PROD_W'(cfg.inv_baseline) * PROD_W'(disp);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    x1 <= col;
    y1 <= row;
    p1 <= prod;
  end

  always_comb begin
    w      = W_W'(p1) + W_W'(cfg.denom_offset);
    wmag   = w[W_W-1] ? DV_W'(-w) : DV_W'(w);
    num[0] = NUM_W'($signed({1'b0, x1, FRAC_BITS'(0)})) + NUM_W'(cfg.cx_offset);
    num[1] = NUM_W'($signed({1'b0, y1, FRAC_BITS'(0)})) + NUM_W'(cfg.cy_offset);
    num[2] = NUM_W'(cfg.focal_term);
    for (int i = 0; i < LANES; i++) begin
      mag[i]      = num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
      scaled[i]   = DQ_W'(mag[i]) * DQ_W'(OUTPUT_SCALE);
      dq_next[i]  = scaled[i] << FRAC_BITS;
      neg_next[i] = num[i][NUM_W-1] ^ w[W_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid  <= v1;
      ctl.zero_w <= (w == '0);
    end
    dq  <= dq_next;
    dv  <= wmag;
    neg <= neg_next;
  end

endmodule

// ===== design/drp_div_cell.sv =====
// One restoring division step for all lanes, with its pipeline registers.
module drp_div_cell import drp_pkg::*; #(
  parameter int DQ_W = 53
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pipe_ctl_t                   ctl_in,
  input  logic [LANES-1:0][DV_W-1:0]  rem_in,
  input  logic [LANES-1:0][DQ_W-1:0]  dq_in,
  input  logic [DV_W-1:0]             dv_in,
  input  logic [LANES-1:0]            neg_in,
  output pipe_ctl_t                   ctl_out,
  output logic [LANES-1:0][DV_W-1:0]  rem_out,
  output logic [LANES-1:0][DQ_W-1:0]  dq_out,
  output logic [DV_W-1:0]             dv_out,
  output logic [LANES-1:0]            neg_out
);

  logic [DV_W:0]                t    [LANES];
  logic [DV_W:0]                diff [LANES];
  logic [LANES-1:0][DV_W-1:0]   rem_next;
  logic [LANES-1:0][DQ_W-1:0]   dq_next;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      t[i]        = {rem_in[i], dq_in[i][DQ_W-1]};
      diff[i]     = t[i] - {1'b0, dv_in};
      rem_next[i] = diff[i][DV_W] ? t[i][DV_W-1:0] : diff[i][DV_W-1:0];
      dq_next[i]  = {dq_in[i][DQ_W-2:0], ~diff[i][DV_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    rem_out <= rem_next;
    dq_out  <= dq_next;
    dv_out  <= dv_in;
    neg_out <= neg_in;
  end

endmodule

// ===== design/drp_back.sv =====
// Sign restore, saturation and result registers.
module drp_back import drp_pkg::*; #(
  parameter int DQ_W = 53
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pipe_ctl_t                   ctl_in,
  input  logic [LANES-1:0][DQ_W-1:0]  q,
  input  logic [LANES-1:0]            neg,
  output logic                        done,
  output logic [LANES-1:0][OUT_W-1:0] pts,
  output logic                        invalid
);

  logic [DQ_W-1:0]              hi [LANES];
  logic [LANES-1:0]             sat;
  logic [LANES-1:0][OUT_W-1:0]  pts_next;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      hi[i] = q[i] >> (OUT_W - 1);
      if (ctl_in.zero_w) begin
        sat[i]      = 1'b0;
        pts_next[i] = '0;
      end else if (neg[i]) begin
        sat[i] = (hi[i] > DQ_W'(1)) || ((hi[i] == DQ_W'(1)) && (q[i][OUT_W-2:0] != '0));
        pts_next[i] = sat[i] ? {1'b1, {(OUT_W-1){1'b0}}} : OUT_W'(-q[i]);
      end else begin
        sat[i]      = (hi[i] != '0);
        pts_next[i] = sat[i] ? {1'b0, {(OUT_W-1){1'b1}}} : OUT_W'(q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
    pts     <= pts_next;
    invalid <= ctl_in.zero_w || (sat != '0);
  end

endmodule

// ===== design/disparity_to_3d_reproject.sv =====
// Top level of the stereo disparity to 3D point reprojection pipeline.
//
//  channel   signals                                  handshake
//  input     pixel_col, pixel_row, disparity          start && !busy
//  result    point_x, point_y, point_z, invalid       done, one cycle
//  config    cfg_addr, cfg_data                       cfg_wr
//
// One word enters per cycle while busy is low; each result passes through the
// operand registers, the chain of one-bit divider cells and the result registers.
// busy is high only during reset; reset loads the config defaults and clears pipeline valids.
// The receiver cannot stall, so the pipeline never holds.
module disparity_to_3d_reproject import drp_pkg::*; #(
  parameter int COORD_BITS   = 12,
  parameter int OUTPUT_SCALE = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [COORD_BITS-1:0]    pixel_col,
  input  logic [COORD_BITS-1:0]    pixel_row,
  input  logic signed [15:0]       disparity,
  output logic                     done,
  output logic signed [OUT_W-1:0]  point_x,
  output logic signed [OUT_W-1:0]  point_y,
  output logic signed [OUT_W-1:0]  point_z,
  output logic                     invalid,
  input  logic                     cfg_wr,
  input  logic [IDX_W-1:0]         cfg_addr,
  input  logic [REG_W-1:0]         cfg_data
);

  localparam int DQ_W = divd_width(COORD_BITS, OUTPUT_SCALE);

  cfg_t cfg;

  pipe_ctl_t                   ctl_c [DQ_W+1];
  logic [LANES-1:0][DV_W-1:0]  rem_c [DQ_W+1];
  logic [LANES-1:0][DQ_W-1:0]  dq_c  [DQ_W+1];
  logic [DV_W-1:0]             dv_c  [DQ_W+1];
  logic [LANES-1:0]            neg_c [DQ_W+1];
  logic [LANES-1:0][OUT_W-1:0] pts;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cx_offset    <= '0;
      cfg.cy_offset    <= '0;
      cfg.focal_term   <= FRAC_ONE;
      cfg.inv_baseline <= '0;
      cfg.denom_offset <= FRAC_ONE;
    end else if (cfg_wr) begin
      case (cfg_addr)
        REG_CX_OFFSET:    cfg.cx_offset    <= cfg_data;
        REG_CY_OFFSET:    cfg.cy_offset    <= cfg_data;
        REG_FOCAL_TERM:   cfg.focal_term   <= cfg_data;
        REG_INV_BASELINE: cfg.inv_baseline <= cfg_data;
        REG_DENOM_OFFSET: cfg.denom_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  drp_front #(.COORD_BITS(COORD_BITS), .OUTPUT_SCALE(OUTPUT_SCALE)) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .accept (start && !busy),
    .col    (pixel_col),
    .row    (pixel_row),
    .disp   (disparity),
    .ctl    (ctl_c[0]),
    .dq     (dq_c[0]),
    .dv     (dv_c[0]),
    .neg    (neg_c[0])
  );

  assign rem_c[0] = '0;

  for (genvar k = 0; k < DQ_W; k++) begin : g_cell
    drp_div_cell #(.DQ_W(DQ_W)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_c[k]),
      .rem_in  (rem_c[k]),
      .dq_in   (dq_c[k]),
      .dv_in   (dv_c[k]),
      .neg_in  (neg_c[k]),
      .ctl_out (ctl_c[k+1]),
      .rem_out (rem_c[k+1]),
      .dq_out  (dq_c[k+1]),
      .dv_out  (dv_c[k+1]),
      .neg_out (neg_c[k+1])
    );
  end

  drp_back #(.DQ_W(DQ_W)) u_back (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_c[DQ_W]),
    .q       (dq_c[DQ_W]),
    .neg     (neg_c[DQ_W]),
    .done    (done),
    .pts     (pts),
    .invalid (invalid)
  );

  assign point_x = pts[0];
  assign point_y = pts[1];
  assign point_z = pts[2];

endmodule

// ===== design/drp_checker.sv =====
// Port-level checks for the reprojection pipeline, bound to the top level.
module drp_checker import drp_pkg::*; #(
  parameter int COORD_BITS   = 12,
  parameter int OUTPUT_SCALE = 16
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  localparam int LAT = latency(COORD_BITS, OUTPUT_SCALE);

  a_word_out: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without matching word");

  a_flush: assert property (@(posedge clk) disable iff (rst)
    done |-> !$past(rst, 1))
    else $error("result right after reset");

endmodule

bind disparity_to_3d_reproject drp_checker #(
  .COORD_BITS(COORD_BITS), .OUTPUT_SCALE(OUTPUT_SCALE)
) u_drp_checker (.*);

// ===== test/reproject_checker.sv =====
// Checker for the disparity reprojection block: predicts each 3D point and compares results.
module reproject_checker import drp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [11:0]             pixel_col,
  input  logic [11:0]             pixel_row,
  input  logic signed [15:0]      disparity,
  input  logic                    done,
  input  logic signed [OUT_W-1:0] point_x,
  input  logic signed [OUT_W-1:0] point_y,
  input  logic signed [OUT_W-1:0] point_z,
  input  logic                    invalid,
  input  logic                    cfg_wr,
  input  logic [IDX_W-1:0]        cfg_addr,
  input  logic [REG_W-1:0]        cfg_data,
  output int                      fails,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint POS_LIMIT = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint NEG_LIMIT = -POS_LIMIT - 1;

  typedef struct {
    logic signed [OUT_W-1:0] px;
    logic signed [OUT_W-1:0] py;
    logic signed [OUT_W-1:0] pz;
    logic                    bad;
  } point_t;

  cfg_t   regs;
  point_t point_q[$];

  function automatic logic signed [OUT_W-1:0] scale_div(longint num, longint w, inout logic bad);
    longint q;
    q = (num * 16 * 65536) / w;
    if (q > POS_LIMIT) begin
      bad = 1'b1;
      return POS_LIMIT[OUT_W-1:0];
    end
    if (q < NEG_LIMIT) begin
      bad = 1'b1;
      return NEG_LIMIT[OUT_W-1:0];
    end
    return q[OUT_W-1:0];
  endfunction

  function automatic point_t reproject(logic [11:0] col, logic [11:0] row,
                                       logic signed [15:0] d);
    point_t p;
    longint w;
    w = longint'(regs.inv_baseline) * longint'(d) + longint'(regs.denom_offset);
    p.px = '0;
    p.py = '0;
    p.pz = '0;
    p.bad = 1'b0;
    if (w == 0) begin
      p.bad = 1'b1;
    end else begin
      p.px = scale_div(longint'(col) * 65536 + longint'(regs.cx_offset), w, p.bad);
      p.py = scale_div(longint'(row) * 65536 + longint'(regs.cy_offset), w, p.bad);
      p.pz = scale_div(longint'(regs.focal_term), w, p.bad);
    end
    return p;
  endfunction

  always @(posedge clk) begin
    point_t e;
    if (rst) begin
      regs.cx_offset    <= '0;
      regs.cy_offset    <= '0;
      regs.focal_term   <= FRAC_ONE;
      regs.inv_baseline <= '0;
      regs.denom_offset <= FRAC_ONE;
      point_q.delete();
    end else begin
      if (done) begin
        if (point_q.size() == 0) begin
          $error("unexpected result x=%0d y=%0d z=%0d", point_x, point_y, point_z);
          fails++;
        end else begin
          e = point_q.pop_front();
          if (point_x !== e.px) begin
            $error("point_x expected %0d actual %0d", e.px, point_x);
            fails++;
          end
          if (point_y !== e.py) begin
            $error("point_y expected %0d actual %0d", e.py, point_y);
            fails++;
          end
          if (point_z !== e.pz) begin
            $error("point_z expected %0d actual %0d", e.pz, point_z);
            fails++;
          end
          if (invalid !== e.bad) begin
            $error("invalid expected %0d actual %0d", e.bad, invalid);
            fails++;
          end
        end
      end
      if (start && !busy) point_q.push_back(reproject(pixel_col, pixel_row, disparity));
      if (cfg_wr) begin
        case (cfg_addr)
          REG_CX_OFFSET:    regs.cx_offset    <= cfg_data;
          REG_CY_OFFSET:    regs.cy_offset    <= cfg_data;
          REG_FOCAL_TERM:   regs.focal_term   <= cfg_data;
          REG_INV_BASELINE: regs.inv_baseline <= cfg_data;
          REG_DENOM_OFFSET: regs.denom_offset <= cfg_data;
          default: ;
        endcase
      end
    end
    pending <= point_q.size();
  end

  initial begin
    fails = 0;
    pending = 0;
  end
endmodule

// ===== test/tb_top.sv =====
// Testbench top for the disparity reprojection block: stimulus, clock, reset and verdict.
module tb_top import drp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic [11:0]             pixel_col = '0;
  logic [11:0]             pixel_row = '0;
  logic signed [15:0]      disparity = '0;
  logic                    done;
  logic signed [OUT_W-1:0] point_x, point_y, point_z;
  logic                    invalid;
  logic                    cfg_wr = 1'b0;
  logic [IDX_W-1:0]        cfg_addr = '0;
  logic [REG_W-1:0]        cfg_data = '0;
  int                      fails, pending;
  bit                      gaps_on;

  disparity_to_3d_reproject dut (.*);

  reproject_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_word(logic [11:0] c, logic [11:0] r, logic signed [15:0] d);
    while (gaps_on && $urandom_range(99) < 16) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    pixel_col <= c;
    pixel_row <= r;
    disparity <= d;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] v);
    cfg_wr   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    cfg_wr <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_cfg(logic [REG_W-1:0] cx, logic [REG_W-1:0] cy, logic [REG_W-1:0] f,
                          logic [REG_W-1:0] ib, logic [REG_W-1:0] dn);
    write_reg(REG_CX_OFFSET, cx);
    write_reg(REG_CY_OFFSET, cy);
    write_reg(REG_FOCAL_TERM, f);
    write_reg(REG_INV_BASELINE, ib);
    write_reg(REG_DENOM_OFFSET, dn);
    cfg_wr <= 1'b0;
  endtask

  function automatic logic [REG_W-1:0] rand_reg();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return REG_W'($signed($urandom_range(8191)) - 4096) <<< $urandom_range(16);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [15:0] rand_disp();
    case ($urandom_range(3))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    gaps_on = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    send_word(12'd0, 12'd0, 16'sd0);
    send_word(12'hFFF, 12'hFFF, 16'sh7FFF);
    send_word(12'hFFF, 12'd0, 16'sh8000);
    drain();
    load_cfg(32'hFFFF_0000, 32'h0001_8000, 32'h7FFF_FFFF, 32'h0001_0000, 32'hFFFB_0000);
    send_word(12'd3, 12'd7, 16'sd5);
    send_word(12'd100, 12'd200, 16'sd4);
    send_word(12'hFFF, 12'hFFF, 16'sh8000);
    send_word(12'd0, 12'hFFF, 16'sh7FFF);
    drain();
    load_cfg(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'd1);
    send_word(12'd0, 12'd0, 16'sd0);
    send_word(12'hFFF, 12'hFFF, 16'sd1);
    drain();
    load_cfg(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(12'hFFF, 12'd0, 16'sh7FFF);
    send_word(12'd0, 12'hFFF, 16'sh8000);
    send_word(12'd1, 12'd2, 16'sd0);
    send_word(12'd2048, 12'd1024, -16'sd1);
    drain();
    load_cfg(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    send_word(12'd5, 12'd6, 16'sd7);
    drain();
    write_reg(3'd5, 32'h1234_5678);
    write_reg(3'd7, 32'hFFFF_FFFF);
    write_reg(3'd6, 32'h0);
    cfg_wr <= 1'b0;
    send_word(12'd9, 12'd9, 16'sd9);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 0) begin
        load_cfg(32'h0010_0000, 32'hFFF0_0000, 32'h0100_0000, 32'h0000_4000, 32'h0040_0000);
      end else begin
        load_cfg(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
      end
      gaps_on = (ph != 1);
      for (int i = 0; i < 50; i++) send_word(12'($urandom()), 12'($urandom()), rand_disp());
      drain();
    end

    repeat (60) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
